// ===== design/asid_pkg.sv =====
// Package for the address-space id allocator: sizes, payload words,
// status codes, sequencer states and the table command struct.
// No dependencies.
package asid_pkg;

    localparam int NUM_SPACES  = 16;
    localparam int SLOT_W      = 5;
    localparam int ID_W        = 16;
    localparam int IDX_W       = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
    // granted_slot is five bits wide, so slots above 31 are never handed out
    localparam int GRANT_LIMIT = (NUM_SPACES > 31) ? 31 : NUM_SPACES;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_REFUSED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   proc_id;
        logic [SLOT_W-1:0] slot;
    } req_word_t;

    typedef struct packed {
        logic [SLOT_W-1:0] granted_slot;
        status_t           status;
    } rsp_word_t;

    // one access to the owner table per cycle: compare at addr, optional write
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [ID_W-1:0]  key;
        logic [ID_W-1:0]  wdata;
    } table_cmd_t;

endpackage

// ===== design/asid_table.sv =====
// Owner table of the allocator with its single shared compare unit.
// Depends on asid_pkg.
module asid_table (
    input  logic                  clk,
    input  logic                  rst_n,
    input  asid_pkg::table_cmd_t  cmd,
    output logic                  match
);

    logic [asid_pkg::ID_W-1:0] owner_reg [asid_pkg::NUM_SPACES];

    // the one comparator: entry at the current address against the key
    assign match = (owner_reg[cmd.addr] == cmd.key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < asid_pkg::NUM_SPACES; i++)
            begin
                owner_reg[i] <= '0;
            end
        end
        else if (cmd.we)
        begin
            owner_reg[cmd.addr] <= cmd.wdata;
        end
    end

endmodule

// ===== design/asid_seq.sv =====
// Sequencer of the allocator: steps the shared compare unit over the
// owner table, one slot a cycle, and forms the result word.
// Depends on asid_pkg.
module asid_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  asid_pkg::req_word_t   req,
    input  logic                  match,
    output asid_pkg::table_cmd_t  cmd,
    output logic                  busy,
    output logic                  done,
    output asid_pkg::rsp_word_t   result
);

    asid_pkg::state_t                  state_reg, state_next;
    logic [asid_pkg::IDX_W-1:0]        addr_reg, addr_next;
    logic [asid_pkg::ID_W-1:0]         id_reg, id_next;
    asid_pkg::status_t                 stat_reg, stat_next;

    logic                              slot_ok;
    logic                              last_slot;
    logic [asid_pkg::SLOT_W-1:0]       scan_slot;

    assign slot_ok   = (req.slot != '0)
                    && (int'(req.slot) <= asid_pkg::NUM_SPACES);
    assign last_slot = (int'(addr_reg) == asid_pkg::GRANT_LIMIT - 1);
    assign scan_slot = asid_pkg::SLOT_W'(addr_reg) + asid_pkg::SLOT_W'(1);
    assign busy      = (state_reg != asid_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asid_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        id_reg   <= id_next;
        stat_reg <= stat_next;
    end

    always_comb
    begin
        state_next          = state_reg;
        addr_next           = addr_reg;
        id_next             = id_reg;
        stat_next           = stat_reg;
        cmd.we              = 1'b0;
        cmd.addr            = addr_reg;
        cmd.key             = '0;
        cmd.wdata           = id_reg;
        done                = 1'b0;
        result.granted_slot = '0;
        result.status       = stat_reg;

        unique case (state_reg)
            asid_pkg::S_IDLE:
            begin
                if (start)
                begin
                    id_next = req.proc_id;
                    if (req.req_type == asid_pkg::REQ_ACQUIRE)
                    begin
                        addr_next = '0;
                        if (req.proc_id == '0)
                        begin
                            stat_next  = asid_pkg::ST_NONE_FREE;
                            state_next = asid_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = asid_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        addr_next = asid_pkg::IDX_W'(req.slot - asid_pkg::SLOT_W'(1));
                        if ((req.proc_id == '0) || !slot_ok)
                        begin
                            stat_next  = asid_pkg::ST_REFUSED;
                            state_next = asid_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = asid_pkg::S_CHECK;
                        end
                    end
                end
            end

            asid_pkg::S_SCAN:
            begin
                // free entry reads as zero
                cmd.key = '0;
                if (match)
                begin
                    cmd.we              = 1'b1;
                    cmd.wdata           = id_reg;
                    done                = 1'b1;
                    result.granted_slot = scan_slot;
                    result.status       = asid_pkg::ST_OK;
                    state_next          = asid_pkg::S_IDLE;
                end
                else if (last_slot)
                begin
                    done          = 1'b1;
                    result.status = asid_pkg::ST_NONE_FREE;
                    state_next    = asid_pkg::S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + asid_pkg::IDX_W'(1);
                end
            end

            asid_pkg::S_CHECK:
            begin
                cmd.key    = id_reg;
                cmd.wdata  = '0;
                cmd.we     = match;
                done       = 1'b1;
                result.status = match ? asid_pkg::ST_OK : asid_pkg::ST_REFUSED;
                state_next = asid_pkg::S_IDLE;
            end

            asid_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = asid_pkg::S_IDLE;
            end

            default:
            begin
                state_next = asid_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/address_space_id_allocator_top.sv =====
// Address-space id allocator, first fit over an owner table of slots.
//
// Request channel (req_valid, req_stall, req): one word per acquire or
// release. Response channel (rsp_valid, rsp_stall, rsp): exactly one word
// per request, in request order.
//
// An acquire scans the owner table from slot 1 upwards, one slot a cycle
// through a single comparator; the first free slot is given to proc_id.
// The scan looks at 1 to 16 slots before its result goes to the response
// register. A release checks the named slot once; a request refused before
// the table is touched goes straight to the done state. The block takes no
// new request until the previous response is registered.
//
// req_stall is high while a request is being worked on, and while a
// response waits in the output register under rsp_stall. A stalled
// response holds its word until taken.
// Reset clears every owner entry at once (all slots free) and empties the
// output register; the block is ready in the first cycle after reset.
// Depends on asid_pkg, asid_seq and asid_table.
module address_space_id_allocator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  asid_pkg::req_word_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output asid_pkg::rsp_word_t  rsp
);

    asid_pkg::table_cmd_t  cmd;
    asid_pkg::rsp_word_t   result;
    logic                  match;
    logic                  busy;
    logic                  done;
    logic                  start;

    logic                  rsp_valid_reg, rsp_valid_next;
    asid_pkg::rsp_word_t   rsp_reg, rsp_next;

    assign req_stall = busy || (rsp_valid_reg && rsp_stall);
    assign start     = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    asid_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .match  (match),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    asid_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .match (match)
    );

    // output word register; it is always empty by the time a result lands
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

// ===== verif/address_space_id_allocator_top_test.sv =====
// Self-checking bench for address_space_id_allocator_top: first-fit slot grants and
// owner-checked releases, predicted from a local owner table and checked word by word.
// Depends on asid_pkg and the design sources.
module address_space_id_allocator_top_test;

    import asid_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 24;
    localparam int RANDOM_PER_PHASE = 630;

    typedef logic [NUM_SPACES-1:0][ID_W-1:0] owner_tab_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    req_word_t  req_backlog[$];
    rsp_word_t  due_rsp[$];
    owner_tab_t plan_owners;
    owner_tab_t live_owners;
    logic       word_taken;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         mismatches;
    int         quiet_cycles;

    address_space_id_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // First fit over slots 1..GRANT_LIMIT; a release needs an in-range slot held by the id.
    function automatic rsp_word_t apply_request(inout owner_tab_t tab, input req_word_t w);
        rsp_word_t r;
        logic      found;
        r.granted_slot = '0;
        found = 1'b0;
        if (w.req_type == REQ_ACQUIRE)
        begin
            r.status = ST_NONE_FREE;
            if (w.proc_id != '0)
            begin
                for (int s = 1; s <= GRANT_LIMIT; s++)
                begin
                    if (!found && tab[s-1] == '0)
                    begin
                        tab[s-1] = w.proc_id;
                        r.granted_slot = SLOT_W'(s);
                        r.status = ST_OK;
                        found = 1'b1;
                    end
                end
            end
        end
        else
        begin
            r.status = ST_REFUSED;
            if (w.proc_id != '0 && w.slot != '0 && int'(w.slot) <= NUM_SPACES)
            begin
                if (tab[w.slot-1] == w.proc_id)
                begin
                    tab[w.slot-1] = '0;
                    r.status = ST_OK;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // plan_owners follows the backlog in order, so generated releases can aim at owned slots
    task automatic queue_word(input logic kind, input logic [ID_W-1:0] id,
                              input logic [SLOT_W-1:0] s);
        req_word_t w;
        rsp_word_t unused;
        w.req_type = kind;
        w.proc_id = id;
        w.slot = s;
        unused = apply_request(plan_owners, w);
        req_backlog.push_back(w);
    endtask

    task automatic queue_random(input int n);
        int              acq_pct;
        int              roll;
        int              used;
        int              pick;
        int              at;
        logic [ID_W-1:0] id;
        acq_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i % 48 == 0)
                acq_pct = $urandom_range(85, 15);
            used = 0;
            for (int k = 0; k < NUM_SPACES; k++)
                if (plan_owners[k] != '0)
                    used++;
            // pick one held slot at random for the owner-aware cases
            at = -1;
            if (used > 0)
            begin
                pick = $urandom_range(used - 1);
                for (int k = 0; k < NUM_SPACES; k++)
                begin
                    if (plan_owners[k] != '0)
                    begin
                        if (pick == 0)
                            at = k;
                        pick--;
                    end
                end
            end
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                case ($urandom_range(5))
                    0: queue_word(REQ_ACQUIRE, '0, SLOT_W'($urandom_range(31)));
                    1: queue_word(REQ_RELEASE, '0, SLOT_W'($urandom_range(31)));
                    2: queue_word(REQ_RELEASE, ID_W'($urandom_range(65535, 1)), '0);
                    3: queue_word(REQ_RELEASE, ID_W'($urandom_range(65535, 1)),
                                  SLOT_W'($urandom_range(31, NUM_SPACES + 1)));
                    4: queue_word(REQ_RELEASE, ID_W'($urandom_range(6, 1)),
                                  SLOT_W'($urandom_range(NUM_SPACES, 1)));
                    default:
                    begin
                        if (at >= 0)
                        begin
                            id = plan_owners[at] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
                            queue_word(REQ_RELEASE, id, SLOT_W'(at + 1));
                        end
                        else
                            queue_word(REQ_RELEASE, ID_W'($urandom_range(65535, 1)),
                                       SLOT_W'($urandom_range(NUM_SPACES, 1)));
                    end
                endcase
            end
            else if (roll < 15 + (85 * acq_pct) / 100 || at < 0)
            begin
                if ($urandom_range(3) != 0)
                    id = ID_W'($urandom_range(6, 1));
                else
                    id = ID_W'($urandom_range(65535, 1));
                queue_word(REQ_ACQUIRE, id, SLOT_W'($urandom_range(31)));
            end
            else
                queue_word(REQ_RELEASE, plan_owners[at], SLOT_W'(at + 1));
        end
    endtask

    // driver: a new word only once the current one has gone or none is offered
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || word_taken)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n)
        begin
            word_taken <= req_valid && !req_stall;
            if (req_valid && !req_stall)
                due_rsp.push_back(apply_request(live_owners, req));
            if (rsp_valid && !rsp_stall)
            begin
                if (due_rsp.size() == 0)
                    report_mismatch($sformatf("response slot %0d status %0d with none due",
                                              rsp.granted_slot, rsp.status));
                else
                begin
                    want = due_rsp.pop_front();
                    if (rsp.granted_slot !== want.granted_slot)
                        report_mismatch($sformatf("granted_slot %0d, wanted %0d",
                                                  rsp.granted_slot, want.granted_slot));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  rsp.status, want.status));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("address_space_id_allocator_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        word_taken = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        plan_owners = '0;
        live_owners = '0;
        send_idle_pct = 21;
        recv_idle_pct = 51;

        // directed: edge ids, every refusal reason, reuse of the lowest slot, full table
        queue_word(REQ_ACQUIRE, 16'hFFFF, 5'd31);
        queue_word(REQ_ACQUIRE, 16'd1, 5'd0);
        queue_word(REQ_ACQUIRE, 16'd0, 5'd0);
        queue_word(REQ_RELEASE, 16'd0, 5'd1);
        queue_word(REQ_RELEASE, 16'd1, 5'd0);
        queue_word(REQ_RELEASE, 16'd1, 5'd17);
        queue_word(REQ_RELEASE, 16'd1, 5'd31);
        queue_word(REQ_RELEASE, 16'hFFFF, 5'd2);
        queue_word(REQ_RELEASE, 16'd1, 5'd5);
        queue_word(REQ_RELEASE, 16'hFFFF, 5'd1);
        queue_word(REQ_ACQUIRE, 16'h1234, 5'd16);
        for (int k = 0; k < NUM_SPACES - 2; k++)
            queue_word(REQ_ACQUIRE, ID_W'(16'h8000 >> k) | ID_W'(k), SLOT_W'(k));
        queue_word(REQ_ACQUIRE, 16'h5A5A, 5'd0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        queue_random(RANDOM_PER_PHASE);
        while (req_backlog.size() != 0)
            @(posedge clk);
        send_idle_pct = 51;
        recv_idle_pct = 21;
        queue_random(RANDOM_PER_PHASE);
        while (req_backlog.size() != 0)
            @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(RANDOM_PER_PHASE);

        while (req_backlog.size() != 0 || req_valid || due_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (due_rsp.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", due_rsp.size()));
        if (mismatches == 0)
            $display("address_space_id_allocator_top regression: pass");
        else
            $display("address_space_id_allocator_top regression: fail");
        $finish;
    end

endmodule
